>>> rtl/core/stree_pkg.sv
`timescale 1ns / 1ps

package stree_pkg;

  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned NODE_W     = 42;
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // request codes
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_SUM = 1'b1;

  // register index, taken from the word address bit
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_QLO,
    ST_QHI
  } state_t;

endpackage

>>> rtl/core/segment_tree_range_sum.sv
`timescale 1ns / 1ps

// segment tree range sum with point update
//
// input channel: a word is taken at a rising edge with start high and busy low.
//   in_req_type selects a set (write one element) or a range-sum query.
// result channel: each query gives one word on out_range_sum, marked by
//   out_valid for exactly one cycle; the receiver cannot stall it, so it must
//   take the word in that cycle. a set gives no result word.
// config: apb-style port, element_count at byte address 0; pready is always
//   high and a write lands on the access cycle. write only while busy is low.
// steps: a set walks leaf to root, one node a cycle, with log2(2N) node
//   writes. a query steps up to two nodes per tree level through the single
//   read port of the node store and the one shared adder; the result word
//   shows in the cycle after its last step, with busy low again, and the next
//   word can be taken in that same cycle. the shared adder and the one read
//   port set how long a set or a query keeps busy high. a set out of range is
//   taken without busy going high.
// reset: the node store is swept to zero, one node a cycle, so busy stays
//   high after reset is released until all 2*MAX_ELEMENTS nodes are cleared;
//   config writes are taken meanwhile. element_count resets to 1024.

module segment_tree_range_sum #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [stree_pkg::IDX_W-1:0]         in_first_index,
  input  logic [stree_pkg::IDX_W-1:0]         in_last_index,
  input  logic signed [stree_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                                out_valid,
  output logic signed [stree_pkg::SUM_W-1:0]  out_range_sum,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stree_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [stree_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stree_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  import stree_pkg::*;

  // node store: root is node 1, leaf i is node MAX_ELEMENTS+i
  localparam int unsigned DEPTH = 2 * MAX_ELEMENTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  // one extra bit so the exclusive upper bound 2N fits
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned CAP_I = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
  localparam logic [CNT_W-1:0] CAP     = CNT_W'(CAP_I);
  localparam logic [AW-1:0]    CLR_END = AW'(DEPTH - 1);
  localparam logic [PW-1:0]    LEAF0   = PW'(MAX_ELEMENTS);
  localparam logic [PW-1:0]    ROOT    = PW'(1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [NODE_W-1:0] acc_r, acc_nxt;
  logic [PW-1:0]     lo_r, lo_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  // node store port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  // request decode
  logic              accept;
  logic [CNT_W-1:0]  cnt_act;
  logic [CNT_W-1:0]  first_ext;
  logic [CNT_W-1:0]  last_ext;
  logic [CNT_W-1:0]  last_clip;
  logic              set_ok;
  logic              q_empty;
  logic [PW-1:0]     leaf_first;
  logic [PW-1:0]     hi_init;
  logic [NODE_W-1:0] value_ext;

  // shared unit
  logic [NODE_W-1:0] sum;
  logic [PW-1:0]     parent;
  logic [PW-1:0]     hi_dec;
  logic              cfg_wr;

  assign accept    = start && (state_r == ST_IDLE);
  assign cnt_act   = (count_r > CAP) ? CAP : count_r;
  assign first_ext = {1'b0, in_first_index};
  assign last_ext  = {1'b0, in_last_index};
  // clip the range end to the last element in use
  assign last_clip = (last_ext > cnt_act - CNT_W'(1)) ? cnt_act - CNT_W'(1) : last_ext;
  assign set_ok    = first_ext < cnt_act;
  assign q_empty   = (cnt_act == '0) || (first_ext > last_clip);
  assign leaf_first = LEAF0 + PW'(in_first_index);
  assign hi_init    = LEAF0 + PW'(last_clip) + PW'(1);
  assign value_ext  = NODE_W'(in_value);

  assign sum    = acc_r + ram_rdata;
  assign parent = lo_r >> 1;
  assign hi_dec = hi_r[0] ? hi_r - PW'(1) : hi_r;

  // ---------------------------------------------------------------- config
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_ELEMENT_COUNT) ?
                  APB_DATA_W'(count_r) : '0;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_END) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_SUM)) begin
          state_nxt = ST_QLO;
        end else if (accept && set_ok) begin
          state_nxt = ST_SET;
        end
      end
      ST_SET: begin
        // root written this cycle ends the walk
        if (parent == ROOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QLO: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_QHI;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QHI: begin
        state_nxt = ST_QLO;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    ram_we        = 1'b0;
    ram_waddr     = lo_r[AW-1:0];
    ram_wdata     = sum;
    ram_raddr     = lo_r[AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_SUM)) begin
          acc_nxt  = '0;
          pend_nxt = 1'b0;
          // an empty range runs no steps and answers zero
          lo_nxt   = q_empty ? '0 : leaf_first;
          hi_nxt   = q_empty ? '0 : hi_init;
        end else if (accept && set_ok) begin
          // write the leaf and fetch its sibling in the same cycle
          ram_we    = 1'b1;
          ram_waddr = leaf_first[AW-1:0];
          ram_wdata = value_ext;
          ram_raddr = leaf_first[AW-1:0] ^ AW'(1);
          acc_nxt   = value_ext;
          lo_nxt    = leaf_first;
        end
      end
      ST_SET: begin
        // parent = running child sum + sibling; fetch the next sibling
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = sum;
        ram_raddr = parent[AW-1:0] ^ AW'(1);
        acc_nxt   = sum;
        lo_nxt    = parent;
      end
      ST_QLO: begin
        if (pend_r) begin
          acc_nxt = sum;
        end
        if (lo_r < hi_r) begin
          ram_raddr = lo_r[AW-1:0];
          pend_nxt  = lo_r[0];
          if (lo_r[0]) begin
            lo_nxt = lo_r + PW'(1);
          end
        end else begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_sum_nxt   = SUM_W'(signed'(acc_nxt));
        end
      end
      ST_QHI: begin
        if (pend_r) begin
          acc_nxt = sum;
        end
        ram_raddr = hi_dec[AW-1:0];
        pend_nxt  = hi_r[0];
        lo_nxt    = lo_r >> 1;
        hi_nxt    = hi_dec >> 1;
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= COUNT_RESET;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_ELEMENT_COUNT)) begin
        count_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    out_sum_r <= out_sum_nxt;
  end

  stree_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = signed'(out_sum_r);

endmodule

>>> rtl/core/stree_ram.sv
`timescale 1ns / 1ps

module stree_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/stree_chk.sv
`timescale 1ns / 1ps

module stree_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_valid
);

  import stree_pkg::*;

  // a result word lasts one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // the block is free again when its result is shown
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // a query always makes the block busy in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_SUM)) |=> busy)
    else $error("query accepted without going busy");

  // a set never produces a result word
  a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_SET)) |=> !out_valid)
    else $error("result word after a set");

endmodule

bind segment_tree_range_sum stree_chk u_stree_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);
